// ===== rtl/core/cstw_pkg.sv =====
// ----------------------------------------------------------------------------
// cstw_pkg
// Shared types, codes and helpers of the counting semaphore with timed waits.
// ----------------------------------------------------------------------------
package cstw_pkg;

  // field widths
  localparam int OpW    = 2;
  localparam int IdW    = 8;
  localparam int TmoW   = 16;
  localparam int CntW   = 16;
  localparam int EvW    = 3;
  localparam int InitW  = 15;
  localparam int ApbDW  = 32;
  localparam int ApbAW  = 3;

  // defaults
  localparam int MaxWaitersDef = 16;
  localparam logic [InitW-1:0] InitReset = InitW'(1);

  // count limits
  localparam logic signed [CntW-1:0] CntMax = 16'sh7fff;
  localparam logic signed [CntW-1:0] CntMin = 16'sh8000;

  // request opcodes
  typedef enum logic [OpW-1:0] {
    OP_WAIT   = 2'd0,
    OP_SIGNAL = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // result events
  typedef enum logic [EvW-1:0] {
    EV_GRANTED = 3'd0,
    EV_BLOCKED = 3'd1,
    EV_WOKEN   = 3'd2,
    EV_TIMEOUT = 3'd3,
    EV_NOWAIT  = 3'd4,
    EV_NOTICK  = 3'd5,
    EV_FULL    = 3'd6
  } ev_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK,
    ST_FIN
  } state_e;

  // register indexes
  typedef enum logic [0:0] {
    REG_INIT_COUNT = 1'b0
  } reg_e;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_PUSH,
    CM_POP,
    CM_STEP
  } cell_mode_e;

  // one queued waiter
  typedef struct packed {
    logic [IdW-1:0]  id;
    logic            timed;
    logic [TmoW-1:0] rem;
  } waiter_t;

  // broadcast control to the cell chain
  typedef struct packed {
    cell_mode_e mode;
    logic       keep;
    waiter_t    ins;
  } cell_ctl_t;

  function automatic logic signed [CntW-1:0] sat_inc(input logic signed [CntW-1:0] v);
    logic signed [CntW-1:0] r;
    r = (v == CntMax) ? v : v + 16'sd1;
    return r;
  endfunction

  function automatic logic signed [CntW-1:0] sat_dec(input logic signed [CntW-1:0] v);
    logic signed [CntW-1:0] r;
    r = (v == CntMin) ? v : v - 16'sd1;
    return r;
  endfunction

endpackage

// ===== rtl/core/cstw_if.sv =====
// ----------------------------------------------------------------------------
// cstw_if
// Request and result channels of the semaphore block, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cstw_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  thread_id;
  logic [15:0] timeout;

  modport source (output valid, opcode, thread_id, timeout, input ready);
  modport sink   (input valid, opcode, thread_id, timeout, output ready);
endinterface

interface cstw_res_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_res;
  logic [7:0]         thread_id_res;
  logic signed [15:0] count;
  logic               last;

  modport source (output valid, event_res, thread_id_res, count, last, input ready);
  modport sink   (input valid, event_res, thread_id_res, count, last, output ready);
endinterface

// ===== rtl/core/counting_semaphore_timed_wait_top.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_timed_wait_top
// One counting semaphore with timed waits: waiter row of cells plus sequencer.
//
//   port   dir  role
//   req    in   wait / signal / tick requests
//   res    out  result events, last flags the final one of a request
//   apb    in   initial_count register at byte address 0
//
// Wait and signal pass through the execute state, then the result register.
// A tick walks the row of MAX_WAITERS cells one slot a cycle, except while the
// result side stalls a timeout report, then gives its last result from the finish state.
// One request is in work at a time; a new one is taken while a result waits.
// Reset loads the count from initial_count (1) and empties the list.
// ----------------------------------------------------------------------------
module counting_semaphore_timed_wait_top #(
  parameter int MAX_WAITERS = cstw_pkg::MaxWaitersDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cstw_req_if.sink                      req,
  cstw_res_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cstw_pkg::ApbAW-1:0]    paddr,
  input  logic [cstw_pkg::ApbDW-1:0]    pwdata,
  output logic [cstw_pkg::ApbDW-1:0]    prdata,
  output logic                          pready
);
  import cstw_pkg::*;

  localparam int PtrW = $clog2(MAX_WAITERS + 1);

  cell_ctl_t        ctl;
  logic [PtrW-1:0]  wptr;
  waiter_t          ent [MAX_WAITERS];
  logic             cfg_we;
  logic             reg_hit;
  logic [InitW-1:0] init_val;

  // register port
  assign pready  = 1'b1;
  assign reg_hit = (reg_e'(paddr[2]) == REG_INIT_COUNT);
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? ApbDW'(init_val) : '0;

  cstw_ctrl #(
    .MAX_WAITERS (MAX_WAITERS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req),
    .res        (res),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (pwdata[InitW-1:0]),
    .init_o     (init_val),
    .head_i     (ent[0]),
    .tail_i     (ent[MAX_WAITERS-1]),
    .ctl_o      (ctl),
    .wptr_o     (wptr)
  );

  // waiter row, head at cell 0
  for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_cell
    cstw_cell #(
      .MAX_WAITERS (MAX_WAITERS),
      .IDX         (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .wptr_i  (wptr),
      .below_i ((i == 0) ? ctl.ins : ent[(i == 0) ? 0 : i - 1]),
      .above_i (ent[(i == MAX_WAITERS - 1) ? i : i + 1]),
      .ent_o   (ent[i])
    );
  end

endmodule

// ===== rtl/core/cstw_cell.sv =====
// ----------------------------------------------------------------------------
// cstw_cell
// One waiter slot of the list; takes its lower or upper neighbor on command.
// ----------------------------------------------------------------------------
module cstw_cell #(
  parameter int MAX_WAITERS = cstw_pkg::MaxWaitersDef,
  parameter int IDX         = 0
) (
  input  logic                                clk_i,
  input  cstw_pkg::cell_ctl_t                 ctl_i,
  input  logic [$clog2(MAX_WAITERS+1)-1:0]    wptr_i,
  input  cstw_pkg::waiter_t                   below_i,
  input  cstw_pkg::waiter_t                   above_i,
  output cstw_pkg::waiter_t                   ent_o
);
  import cstw_pkg::*;

  localparam int PtrW = $clog2(MAX_WAITERS + 1);
  localparam logic [PtrW-1:0] IdxC = PtrW'(IDX);

  waiter_t ent_q, ent_d;
  logic    step_move;

  // during a tick step, survivors push the whole row, drops move only the rest
  assign step_move = ctl_i.keep || (IdxC >= wptr_i);

  always_comb begin
    ent_d = ent_q;
    case (ctl_i.mode)
      CM_PUSH: ent_d = below_i;
      CM_POP:  ent_d = above_i;
      CM_STEP: if (step_move) begin
        ent_d = below_i;
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

// ===== rtl/core/cstw_ctrl.sv =====
// ----------------------------------------------------------------------------
// cstw_ctrl
// Sequencer: count, occupancy, tick pass over the cell row, result register.
// ----------------------------------------------------------------------------
module cstw_ctrl #(
  parameter int MAX_WAITERS = cstw_pkg::MaxWaitersDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  cstw_req_if.sink                            req,
  cstw_res_if.source                          res,
  input  logic                                cfg_we_i,
  input  logic [cstw_pkg::InitW-1:0]          cfg_data_i,
  output logic [cstw_pkg::InitW-1:0]          init_o,
  input  cstw_pkg::waiter_t                   head_i,
  input  cstw_pkg::waiter_t                   tail_i,
  output cstw_pkg::cell_ctl_t                 ctl_o,
  output logic [$clog2(MAX_WAITERS+1)-1:0]    wptr_o
);
  import cstw_pkg::*;

  localparam int PtrW = $clog2(MAX_WAITERS + 1);
  localparam int StpW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam logic [PtrW-1:0] Full    = PtrW'(MAX_WAITERS);
  localparam logic [StpW-1:0] StpLast = StpW'(MAX_WAITERS - 1);
  localparam logic [PtrW:0]   SumN    = (PtrW + 1)'(MAX_WAITERS);

  state_e                 state_q, state_d;
  op_e                    op_q;
  logic [IdW-1:0]         tid_q;
  logic [TmoW-1:0]        tmo_q;
  logic signed [CntW-1:0] cnt_q, cnt_d, cnt_up;
  logic [InitW-1:0]       init_q, init_d;
  logic [PtrW-1:0]        occ_q, occ_d, wptr_q, wptr_d;
  logic [StpW-1:0]        stp_q, stp_d;
  logic                   hold_v_q, hold_v_d;
  logic [IdW-1:0]         hold_id_q, hold_id_d;
  logic signed [CntW-1:0] hold_cnt_q, hold_cnt_d;
  logic                   out_v_q, out_v_d;
  ev_e                    out_ev_q, out_ev_d;
  logic [IdW-1:0]         out_id_q, out_id_d;
  logic signed [CntW-1:0] out_cnt_q, out_cnt_d;
  logic                   out_last_q, out_last_d;
  logic                   req_fire, can_load;
  logic [PtrW:0]          pos_sum;
  logic                   examine, expired, stall;
  logic [TmoW-1:0]        rem_dec;

  assign req.ready = (state_q == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign can_load  = !out_v_q || res.ready;
  assign cnt_up    = sat_inc(cnt_q);

  // tail cell holds a real waiter once the skipped empty slots have gone by
  assign pos_sum = {1'b0, PtrW'(stp_q)} + {1'b0, occ_q};
  assign examine = (pos_sum >= SumN);
  assign rem_dec = tail_i.rem - TmoW'(1);
  assign expired = examine && tail_i.timed && (rem_dec == '0);
  assign stall   = expired && hold_v_q && !can_load;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (req_fire) begin
        case (op_e'(req.opcode))
          OP_WAIT, OP_SIGNAL: state_d = ST_EXEC;
          OP_TICK:            state_d = ST_TICK;
          default:            state_d = ST_IDLE;
        endcase
      end
      ST_EXEC: if (can_load) begin
        state_d = ST_IDLE;
      end
      ST_TICK: if (!stall && stp_q == StpLast) begin
        state_d = ST_FIN;
      end
      ST_FIN: if (can_load) begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and cell commands
  always_comb begin
    cnt_d      = cnt_q;
    init_d     = init_q;
    occ_d      = occ_q;
    wptr_d     = wptr_q;
    stp_d      = stp_q;
    hold_v_d   = hold_v_q;
    hold_id_d  = hold_id_q;
    hold_cnt_d = hold_cnt_q;
    out_v_d    = res.ready ? 1'b0 : out_v_q;
    out_ev_d   = out_ev_q;
    out_id_d   = out_id_q;
    out_cnt_d  = out_cnt_q;
    out_last_d = out_last_q;
    ctl_o.mode = CM_HOLD;
    ctl_o.keep = 1'b0;
    ctl_o.ins  = '{id: tid_q, timed: (tmo_q != '0), rem: tmo_q};

    case (state_q)
      ST_IDLE: if (req_fire && op_e'(req.opcode) == OP_TICK) begin
        stp_d    = '0;
        wptr_d   = '0;
        hold_v_d = 1'b0;
      end
      ST_EXEC: if (can_load) begin
        out_v_d    = 1'b1;
        out_last_d = 1'b1;
        if (op_q == OP_WAIT) begin
          out_id_d = tid_q;
          if (cnt_q > 16'sd0) begin
            cnt_d    = sat_dec(cnt_q);
            out_ev_d = EV_GRANTED;
          end else if (occ_q == Full) begin
            out_ev_d = EV_FULL;
          end else begin
            // new waiter enters at the head of the row
            ctl_o.mode = CM_PUSH;
            cnt_d      = sat_dec(cnt_q);
            occ_d      = occ_q + PtrW'(1);
            out_ev_d   = EV_BLOCKED;
          end
        end else begin
          cnt_d = cnt_up;
          if (cnt_up <= 16'sd0 && occ_q != '0) begin
            // most recent waiter sits at the head
            ctl_o.mode = CM_POP;
            occ_d      = occ_q - PtrW'(1);
            out_ev_d   = EV_WOKEN;
            out_id_d   = head_i.id;
          end else begin
            out_ev_d = EV_NOWAIT;
            out_id_d = '0;
          end
        end
        out_cnt_d = cnt_d;
      end
      ST_TICK: if (!stall) begin
        // tail leaves the row, survivors come back in at the head
        ctl_o.mode = CM_STEP;
        ctl_o.keep = examine && !expired;
        ctl_o.ins  = '{id: tail_i.id, timed: tail_i.timed,
                       rem: tail_i.timed ? rem_dec : tail_i.rem};
        stp_d      = stp_q + StpW'(1);
        if (examine && !expired) begin
          wptr_d = wptr_q + PtrW'(1);
        end
        if (expired) begin
          cnt_d      = cnt_up;
          hold_v_d   = 1'b1;
          hold_id_d  = tail_i.id;
          hold_cnt_d = cnt_up;
          // an earlier timeout goes out, not the final one
          if (hold_v_q) begin
            out_v_d    = 1'b1;
            out_ev_d   = EV_TIMEOUT;
            out_id_d   = hold_id_q;
            out_cnt_d  = hold_cnt_q;
            out_last_d = 1'b0;
          end
        end
      end
      ST_FIN: if (can_load) begin
        out_v_d    = 1'b1;
        out_last_d = 1'b1;
        occ_d      = wptr_q;
        hold_v_d   = 1'b0;
        if (hold_v_q) begin
          out_ev_d  = EV_TIMEOUT;
          out_id_d  = hold_id_q;
          out_cnt_d = hold_cnt_q;
        end else begin
          out_ev_d  = EV_NOTICK;
          out_id_d  = '0;
          out_cnt_d = cnt_q;
        end
      end
      default: ;
    endcase

    // register write reloads the count and empties the list
    if (cfg_we_i) begin
      init_d = cfg_data_i;
      cnt_d  = CntW'({1'b0, cfg_data_i});
      occ_d  = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= CntW'({1'b0, InitReset});
      init_q   <= InitReset;
      occ_q    <= '0;
      wptr_q   <= '0;
      stp_q    <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      init_q   <= init_d;
      occ_q    <= occ_d;
      wptr_q   <= wptr_d;
      stp_q    <= stp_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q  <= op_e'(req.opcode);
      tid_q <= req.thread_id;
      tmo_q <= req.timeout;
    end
    hold_id_q  <= hold_id_d;
    hold_cnt_q <= hold_cnt_d;
    out_ev_q   <= out_ev_d;
    out_id_q   <= out_id_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  assign res.valid         = out_v_q;
  assign res.event_res     = out_ev_q;
  assign res.thread_id_res = out_id_q;
  assign res.count         = out_cnt_q;
  assign res.last          = out_last_q;
  assign init_o            = init_q;
  assign wptr_o            = wptr_q;

endmodule

// ===== tb/counting_semaphore_timed_wait_top_test.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_timed_wait_top_test
// Self-checking bench for the timed-wait counting semaphore. A short table of
// directed requests covers grant, block, wake, quiet signal and tick, ignored
// opcode, full waiter list and a burst of timeouts. Random requests follow, in
// phases with different initial counts and handshake idling. Every result is
// compared field by field with a behavioral copy of the semaphore.
// ----------------------------------------------------------------------------
module counting_semaphore_timed_wait_top_test;
  import cstw_pkg::*;

  localparam int MaxW       = MaxWaitersDef;
  localparam int QuietLimit = 3000;
  localparam int MaxPrints  = 40;

  // one expected result
  typedef struct packed {
    ev_e             ev;
    logic [IdW-1:0]  tid;
    logic [CntW-1:0] cnt;
    logic            last;
  } sem_result_t;

  // first result of a directed row, typed in by hand
  typedef struct packed {
    logic            on;
    ev_e             ev;
    logic [IdW-1:0]  tid;
    logic [CntW-1:0] cnt;
  } typed_result_t;

  // one row of the directed table
  typedef struct {
    op_e             op;
    logic [IdW-1:0]  tid;
    logic [TmoW-1:0] tmo;
    int              reps;
    int              init_wr;
    typed_result_t   typed;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ApbAW-1:0] paddr;
  logic [ApbDW-1:0] pwdata;
  logic [ApbDW-1:0] prdata;
  logic pready;

  cstw_req_if req_ch ();
  cstw_res_if res_ch ();

  counting_semaphore_timed_wait_top #(
    .MAX_WAITERS(MaxW)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .res    (res_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // semaphore copy kept by the bench
  logic [InitW-1:0]        init_level;
  logic signed [CntW-1:0]  sem_level;
  logic [IdW-1:0]          waiter_tid  [MaxW];
  logic [TmoW-1:0]         waiter_span [MaxW];
  logic [TmoW-1:0]         waiter_left [MaxW];
  int                      waiter_cnt;

  sem_result_t   waiting [$];
  typed_result_t typed_want;
  plan_row_t     plan [$];
  int            errors;
  int            src_idle;
  int            sink_stall;
  int            quiet;

  int phase_src  [5] = '{0, 74, 0, 14, 0};
  int phase_sink [5] = '{0, 0, 74, 14, 0};
  int phase_init [5] = '{0, 1, 2, 0, 32767};
  int phase_reqs [5] = '{40, 40, 40, 40, 15};

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    init_level = InitReset;
    sem_level  = CntW'(InitReset);
    waiter_cnt = 0;
    errors     = 0;
    quiet      = 0;
  end

  function automatic logic signed [CntW-1:0] nudge_count(input logic signed [CntW-1:0] v,
                                                         input int step);
    int t;
    t = int'(v) + step;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return CntW'(t);
  endfunction

  // queue the results one request causes and update the copy
  task automatic predict_request(input op_e op, input logic [IdW-1:0] tid,
                                 input logic [TmoW-1:0] tmo);
    int hits;
    int keep;
    logic gone;
    sem_result_t r;
    hits = 0;
    keep = 0;
    case (op)
      OP_WAIT: begin
        if (sem_level > 0) begin
          sem_level = nudge_count(sem_level, -1);
          waiting.push_back('{EV_GRANTED, tid, sem_level, 1'b1});
        end else if (waiter_cnt >= MaxW) begin
          waiting.push_back('{EV_FULL, tid, sem_level, 1'b1});
        end else begin
          sem_level = nudge_count(sem_level, -1);
          waiter_tid[waiter_cnt]  = tid;
          waiter_span[waiter_cnt] = tmo;
          waiter_left[waiter_cnt] = tmo;
          waiter_cnt++;
          waiting.push_back('{EV_BLOCKED, tid, sem_level, 1'b1});
        end
      end
      OP_SIGNAL: begin
        sem_level = nudge_count(sem_level, 1);
        if (sem_level <= 0 && waiter_cnt > 0) begin
          // newest waiter leaves first
          waiter_cnt--;
          waiting.push_back('{EV_WOKEN, waiter_tid[waiter_cnt], sem_level, 1'b1});
        end else begin
          waiting.push_back('{EV_NOWAIT, 8'h00, sem_level, 1'b1});
        end
      end
      OP_TICK: begin
        for (int i = 0; i < waiter_cnt; i++) begin
          gone = 1'b0;
          if (waiter_span[i] != 0) begin
            waiter_left[i] = waiter_left[i] - 1'b1;
            gone = (waiter_left[i] == 0);
          end
          if (gone) begin
            sem_level = nudge_count(sem_level, 1);
            waiting.push_back('{EV_TIMEOUT, waiter_tid[i], sem_level, 1'b0});
            hits++;
          end else begin
            // compact the list in order
            waiter_tid[keep]  = waiter_tid[i];
            waiter_span[keep] = waiter_span[i];
            waiter_left[keep] = waiter_left[i];
            keep++;
          end
        end
        waiter_cnt = keep;
        if (hits == 0) begin
          waiting.push_back('{EV_NOTICK, 8'h00, sem_level, 1'b1});
        end else begin
          r = waiting.pop_back();
          r.last = 1'b1;
          waiting.push_back(r);
        end
      end
      default: begin
        // unused opcode, nothing comes back
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MaxPrints)
      $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $time);
  endtask

  // predict on every accepted request, check every accepted result
  always @(posedge clk_i) begin : scoreboard
    sem_result_t want;
    int base;
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        base = waiting.size();
        predict_request(op_e'(req_ch.opcode), req_ch.thread_id, req_ch.timeout);
        if (typed_want.on && waiting.size() > base) begin
          want = waiting[base];
          want.ev  = typed_want.ev;
          want.tid = typed_want.tid;
          want.cnt = typed_want.cnt;
          waiting[base] = want;
        end
      end
      if (res_ch.valid && res_ch.ready) begin
        if (waiting.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(res_ch.event_res), 32'h0);
        end else begin
          want = waiting.pop_front();
          if (res_ch.event_res !== want.ev)
            report_mismatch("event_res", 32'(res_ch.event_res), 32'(want.ev));
          if (res_ch.thread_id_res !== want.tid)
            report_mismatch("thread_id_res", 32'(res_ch.thread_id_res), 32'(want.tid));
          if (res_ch.count !== want.cnt)
            report_mismatch("count", 32'(res_ch.count), 32'(want.cnt));
          if (res_ch.last !== want.last)
            report_mismatch("last", 32'(res_ch.last), 32'(want.last));
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= sink_stall);
  end

  // give up when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QuietLimit) begin
        $display("counting_semaphore_timed_wait_top_test: FAIL");
        $finish;
      end
    end
  end

  function automatic plan_row_t plan_row(input op_e op, input logic [IdW-1:0] tid,
                                         input logic [TmoW-1:0] tmo, input int reps,
                                         input int init_wr, input logic on, input ev_e ev,
                                         input logic [IdW-1:0] want_tid,
                                         input int want_cnt);
    plan_row_t r;
    r.op      = op;
    r.tid     = tid;
    r.tmo     = tmo;
    r.reps    = reps;
    r.init_wr = init_wr;
    r.typed   = '{on, ev, want_tid, CntW'(want_cnt)};
    return r;
  endfunction

  // present one request, idling first as the phase asks
  task automatic send_request(input op_e op, input logic [IdW-1:0] tid,
                              input logic [TmoW-1:0] tmo, input typed_result_t typed);
    while ($urandom_range(99) < src_idle) begin
      req_ch.valid     <= 1'b0;
      req_ch.opcode    <= OpW'($urandom_range(3));
      req_ch.thread_id <= IdW'($urandom_range(255));
      req_ch.timeout   <= TmoW'($urandom_range(65535));
      @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.opcode    <= op;
    req_ch.thread_id <= tid;
    req_ch.timeout   <= tmo;
    typed_want       <= typed;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // drain all results, then let a silent request finish
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (waiting.size() != 0) @(posedge clk_i);
    repeat (MaxW + 4) @(posedge clk_i);
  endtask

  // apb write of initial_count, also reloads the count and empties the list
  task automatic write_init_count(input logic [InitW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAW'(4 * int'(REG_INIT_COUNT));
    pwdata  <= ApbDW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    init_level = value;
    sem_level  = CntW'(value);
    waiter_cnt = 0;
    // read the register back
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== ApbDW'(init_level))
      report_mismatch("initial_count readback", prdata, ApbDW'(init_level));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // stimulus
  initial begin : main
    int sent;
    int pick;
    op_e op;
    logic [IdW-1:0] tid;
    logic [TmoW-1:0] tmo;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_ch.valid     = 1'b0;
    req_ch.opcode    = OP_NONE;
    req_ch.thread_id = '0;
    req_ch.timeout   = '0;
    res_ch.ready     = 1'b0;
    typed_want       = '0;
    src_idle         = 0;
    sink_stall       = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: op, tid, timeout, repeats, init write, typed first result
    plan.push_back(plan_row(OP_WAIT,   8'h00, 16'h0000, 1, -1, 1'b1, EV_GRANTED, 8'h00, 0));
    plan.push_back(plan_row(OP_WAIT,   8'hff, 16'hffff, 1, -1, 1'b1, EV_BLOCKED, 8'hff, -1));
    plan.push_back(plan_row(OP_SIGNAL, 8'h00, 16'h0000, 1, -1, 1'b1, EV_WOKEN,   8'hff, 0));
    plan.push_back(plan_row(OP_SIGNAL, 8'h5a, 16'h1234, 1, -1, 1'b1, EV_NOWAIT,  8'h00, 1));
    plan.push_back(plan_row(OP_TICK,   8'hc3, 16'h8001, 1, -1, 1'b1, EV_NOTICK,  8'h00, 1));
    plan.push_back(plan_row(OP_NONE,   8'haa, 16'hffff, 1, -1, 1'b0, EV_GRANTED, 8'h00, 0));
    plan.push_back(plan_row(OP_WAIT,   8'h80, 16'h0001, 15, 0, 1'b0, EV_GRANTED, 8'h00, 0));
    plan.push_back(plan_row(OP_WAIT,   8'h7f, 16'h0000, 1, -1, 1'b1, EV_BLOCKED, 8'h7f, -16));
    plan.push_back(plan_row(OP_WAIT,   8'h55, 16'h0002, 1, -1, 1'b1, EV_FULL,    8'h55, -16));
    plan.push_back(plan_row(OP_TICK,   8'h00, 16'h0000, 1, -1, 1'b0, EV_GRANTED, 8'h00, 0));
    plan.push_back(plan_row(OP_SIGNAL, 8'h00, 16'h0000, 1, -1, 1'b1, EV_WOKEN,   8'h7f, 0));

    foreach (plan[i]) begin
      if (plan[i].init_wr >= 0) begin
        settle();
        write_init_count(InitW'(plan[i].init_wr));
      end
      for (int k = 0; k < plan[i].reps; k++)
        send_request(plan[i].op, IdW'(plan[i].tid + k), plan[i].tmo, plan[i].typed);
    end

    // random phases, each with its own count and idling
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      src_idle   = phase_src[ph];
      sink_stall = phase_sink[ph];
      write_init_count(InitW'(phase_init[ph]));
      sent = 0;
      while (sent < phase_reqs[ph]) begin
        pick = $urandom_range(99);
        op   = (pick < 45) ? OP_WAIT : (pick < 65) ? OP_SIGNAL :
               (pick < 95) ? OP_TICK : OP_NONE;
        tid  = IdW'($urandom_range(255));
        pick = $urandom_range(9);
        // mostly short limits so timeouts happen, some endless, some huge
        if (pick < 2) tmo = '0;
        else if (pick < 8) tmo = TmoW'($urandom_range(4, 1));
        else tmo = TmoW'($urandom_range(65535));
        send_request(op, tid, tmo, '0);
        if (op != OP_NONE) sent++;
      end
    end

    settle();
    if (errors == 0 && waiting.size() == 0) begin
      $display("counting_semaphore_timed_wait_top_test: PASS");
    end else begin
      $display("counting_semaphore_timed_wait_top_test: FAIL");
    end
    $finish;
  end

endmodule
